/* design/tmtw_pkg.sv */
// Shared types, constants and sequencer states for the text mode terminal writer.
// Depends on nothing; every other file of the block imports it.
package tmtw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int POS_W  = 11;
  localparam int LIN_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int SUM_W  = LIN_W + 1;
  localparam int CELL_W = 16;

  // Character codes
  localparam logic [7:0] BLANK_CHAR     = 8'd32;
  localparam logic [7:0] LAST_PRINTABLE = 8'd126;
  localparam logic [7:0] CH_BS          = 8'd8;
  localparam logic [7:0] CH_TAB         = 8'd9;
  localparam logic [7:0] CH_LF          = 8'd10;
  localparam logic [7:0] CH_CR          = 8'd13;
  localparam int         TAB_STOP       = 4;

  // Function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Reset contents and configuration
  localparam logic [CELL_W-1:0] RESET_CELL       = 16'h0F20;
  localparam logic [7:0]        BLANK_ATTR_RESET = 8'h0F;
  localparam int                PADDR_W          = 3;
  localparam logic              REG_BLANK_ATTR   = 1'b0;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       char_code;
    logic [7:0]       attribute;
    logic [POS_W-1:0] read_position;
  } tmtw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } tmtw_out_t;

  // Request from the sequencer to the address unit
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic [ROW_W-1:0]  row;
    logic [LIN_W-1:0]  offset;
    logic [CELL_W-1:0] data;
  } tmtw_req_t;

  // Memory command from the address unit
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } tmtw_cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_BS,
    ST_SCROLL_SETUP,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ_REQ,
    ST_READ_WAIT,
    ST_READ_CAP,
    ST_POS,
    ST_DONE
  } tmtw_state_t;

endpackage

/* design/tmtw_screen_mem.sv */
// Character-cell screen store: one write or one registered read per cycle.
// Depends on tmtw_pkg for the command type and store geometry.
module tmtw_screen_mem (
  input  logic                       clk,
  input  tmtw_pkg::tmtw_cmd_t        cmd,
  output logic [tmtw_pkg::CELL_W-1:0] rdata
);
  import tmtw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  // Write or read the addressed cell
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.wr) begin
      mem[cmd.addr] <= cmd.data;
    end
    if (cmd.valid && !cmd.wr) begin
      rdata <= mem[cmd.addr];
    end
  end

endmodule

/* design/tmtw_addr_unit.sv */
// Shared address unit: row times columns plus offset, rotated by the top-row base.
// Depends on tmtw_pkg; feeds tmtw_screen_mem and returns the linear position.
module tmtw_addr_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  tmtw_pkg::tmtw_req_t         req,
  input  logic [tmtw_pkg::ADDR_W-1:0] top_base,
  output tmtw_pkg::tmtw_cmd_t         cmd,
  output logic [tmtw_pkg::LIN_W-1:0]  lin
);
  import tmtw_pkg::*;

  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] wrapped;

  // Multiply-add, then fold once into the store
  always_comb begin
    prod    = SUM_W'(req.row) * SUM_W'(COLUMNS);
    base    = prod + SUM_W'(req.offset);
    sum     = base + SUM_W'(top_base);
    wrapped = (sum >= SUM_W'(CELL_COUNT)) ? (sum - SUM_W'(CELL_COUNT)) : sum;
  end

  // Register the command and the linear position
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      cmd.valid <= req.valid;
    end
    cmd.wr   <= req.wr;
    cmd.addr <= wrapped[ADDR_W-1:0];
    cmd.data <= req.data;
    lin      <= base[LIN_W-1:0];
  end

endmodule

/* design/tmtw_seq.sv */
// Sequencer: decodes items, steps the cursor, and drives sweeps through the address unit.
// Depends on tmtw_pkg for types, constants and states.
module tmtw_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  tmtw_pkg::tmtw_in_t          item,
  input  logic [7:0]                  blank_attr,
  input  logic [tmtw_pkg::LIN_W-1:0]  lin,
  input  logic [tmtw_pkg::CELL_W-1:0] rdata,
  output logic                        busy,
  output logic                        done,
  output tmtw_pkg::tmtw_out_t         result,
  output tmtw_pkg::tmtw_req_t         req,
  output logic [tmtw_pkg::ADDR_W-1:0] top_base
);
  import tmtw_pkg::*;

  tmtw_state_t       state, state_next;
  tmtw_in_t          cur, cur_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [ADDR_W-1:0] top_base_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [CELL_W-1:0] cell_val, cell_val_next;
  logic              scrolled, scrolled_next;

  logic              col_last;
  logic              row_last;
  logic              cnt_cells_end;
  logic              cnt_row_end;
  logic              is_tab;
  logic              printable;
  logic [COL_W-1:0]  col_inc;
  logic              tab_more;

  // Decode helpers
  always_comb begin
    col_last      = (col == COL_W'(COLUMNS - 1));
    row_last      = (row == ROW_W'(ROWS - 1));
    cnt_cells_end = (cnt == ADDR_W'(CELL_COUNT - 1));
    cnt_row_end   = (cnt == ADDR_W'(COLUMNS - 1));
    is_tab        = (cur.char_code == CH_TAB);
    printable     = (cur.char_code >= BLANK_CHAR) && (cur.char_code <= LAST_PRINTABLE);
    col_inc       = col + COL_W'(1);
    tab_more      = is_tab && !col_last && ((col_inc & COL_W'(TAB_STOP - 1)) != '0);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt_cells_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        priority if (cur.func == FUNC_PUT) begin
          priority if (cur.char_code == CH_LF) begin
            state_next = row_last ? ST_SCROLL_SETUP : ST_POS;
          end else if (cur.char_code == CH_TAB || printable) begin
            state_next = ST_PUT;
          end else if (cur.char_code == CH_BS && col != '0) begin
            state_next = ST_BS;
          end else begin
            state_next = ST_POS;
          end
        end else if (cur.func == FUNC_READ) begin
          state_next = (32'(cur.read_position) < CELL_COUNT) ? ST_READ_REQ : ST_POS;
        end else if (cur.func == FUNC_CLEAR) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_POS;
        end
      end
      ST_PUT: begin
        priority if (col_last && row_last) state_next = ST_SCROLL_SETUP;
        else if (tab_more)                 state_next = ST_PUT;
        else                               state_next = ST_POS;
      end
      ST_BS:           state_next = ST_POS;
      ST_SCROLL_SETUP: state_next = ST_SCROLL;
      ST_SCROLL: begin
        if (cnt_row_end) state_next = ST_POS;
      end
      ST_CLEAR: begin
        if (cnt_cells_end) state_next = ST_POS;
      end
      ST_READ_REQ:  state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_READ_CAP;
      ST_READ_CAP:  state_next = ST_POS;
      ST_POS:       state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs: store requests, handshake and result
  always_comb begin
    req.valid  = 1'b0;
    req.wr     = 1'b1;
    req.row    = row;
    req.offset = LIN_W'(col);
    req.data   = {cur.attribute, BLANK_CHAR};
    unique case (state)
      ST_INIT: begin
        req.valid  = 1'b1;
        req.row    = '0;
        req.offset = LIN_W'(cnt);
        req.data   = RESET_CELL;
      end
      ST_PUT: begin
        req.valid = 1'b1;
        req.data  = is_tab ? {cur.attribute, BLANK_CHAR} : {cur.attribute, cur.char_code};
      end
      ST_BS: begin
        req.valid = 1'b1;
      end
      ST_SCROLL: begin
        req.valid  = 1'b1;
        req.row    = ROW_W'(ROWS - 1);
        req.offset = LIN_W'(cnt);
        req.data   = {blank_attr, BLANK_CHAR};
      end
      ST_CLEAR: begin
        req.valid  = 1'b1;
        req.row    = '0;
        req.offset = LIN_W'(cnt);
        req.data   = {blank_attr, BLANK_CHAR};
      end
      ST_READ_REQ: begin
        req.valid  = 1'b1;
        req.wr     = 1'b0;
        req.row    = '0;
        req.offset = LIN_W'(cur.read_position);
      end
      default: begin
        req.valid = 1'b0;
      end
    endcase
    busy                   = (state != ST_IDLE);
    done                   = (state == ST_DONE);
    result.cursor_position = lin[POS_W-1:0];
    result.cell_value      = cell_val;
    result.scrolled        = scrolled;
  end

  // Datapath next values
  always_comb begin
    cur_next      = cur;
    col_next      = col;
    row_next      = row;
    top_next      = top;
    top_base_next = top_base;
    cnt_next      = cnt;
    cell_val_next = cell_val;
    scrolled_next = scrolled;
    unique case (state)
      ST_INIT, ST_SCROLL, ST_CLEAR: begin
        cnt_next = cnt + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          cur_next      = item;
          cell_val_next = '0;
          scrolled_next = 1'b0;
        end
      end
      ST_DISPATCH: begin
        priority if (cur.func == FUNC_PUT) begin
          priority if (cur.char_code == CH_LF) begin
            col_next = '0;
            if (!row_last) row_next = row + ROW_W'(1);
          end else if (cur.char_code == CH_CR) begin
            col_next = '0;
          end else if (cur.char_code == CH_BS && col != '0) begin
            col_next = col - COL_W'(1);
          end else begin
            col_next = col;
          end
        end else if (cur.func == FUNC_CLEAR) begin
          col_next      = '0;
          row_next      = '0;
          top_next      = '0;
          top_base_next = '0;
          cnt_next      = '0;
        end else begin
          col_next = col;
        end
      end
      ST_PUT: begin
        if (col_last) begin
          col_next = '0;
          if (!row_last) row_next = row + ROW_W'(1);
        end else begin
          col_next = col_inc;
        end
      end
      ST_SCROLL_SETUP: begin
        top_next      = (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);
        top_base_next = (top_base == ADDR_W'(CELL_COUNT - COLUMNS)) ? '0 :
                        top_base + ADDR_W'(COLUMNS);
        cnt_next      = '0;
        scrolled_next = 1'b1;
      end
      ST_READ_CAP: begin
        cell_val_next = rdata;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  // Hold and advance registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      col      <= '0;
      row      <= '0;
      top      <= '0;
      top_base <= '0;
      cnt      <= '0;
      scrolled <= 1'b0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      row      <= row_next;
      top      <= top_next;
      top_base <= top_base_next;
      cnt      <= cnt_next;
      scrolled <= scrolled_next;
    end
    cur      <= cur_next;
    cell_val <= cell_val_next;
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer not busy");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= COL_W'(COLUMNS - 1))
    else $error("cursor column past row end");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_W'(ROWS - 1))
    else $error("cursor row past last row");
  a_top_base: assert property (@(posedge clk) disable iff (rst)
    top_base == ADDR_W'(32'(top) * COLUMNS))
    else $error("top-row base out of step with top-row offset");
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (done && result.scrolled) |-> row_last)
    else $error("scroll did not leave cursor on last row");
`endif

endmodule

/* design/text_mode_terminal_writer_unit.sv */
// Top level of the text mode terminal writer: configuration register and wiring.
// Depends on tmtw_pkg, tmtw_seq, tmtw_addr_unit and tmtw_screen_mem.
//
// Channel    Direction  Handshake                  Payload
// request    in         start && !busy             item   (tmtw_in_t)
// result     out        done (one cycle)           result (tmtw_out_t)
// config     in         APB psel/penable/pwrite    pwdata[7:0] -> blank attribute
//
// After reset the store is cleared one cell a cycle, all CELL_COUNT (2000) cells, with busy high.
// Printable codes and backspace write one cell; a tab writes blanks up to the next tab stop.
// A read off screen skips the store. A scroll clears one row via the store.
// Clear screen writes every cell through the single store port.
// The result strobe cannot be stalled; busy drops in the cycle after done, then a new request.
module text_mode_terminal_writer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tmtw_pkg::tmtw_in_t           item,
  output logic                         done,
  output tmtw_pkg::tmtw_out_t          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmtw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tmtw_pkg::*;

  logic [7:0]        blank_attr;
  tmtw_req_t         req;
  tmtw_cmd_t         cmd;
  logic [LIN_W-1:0]  lin;
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] top_base;
  logic              reg_hit;

  // Decode the register file
  assign reg_hit = (paddr[PADDR_W-1] == REG_BLANK_ATTR);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {24'd0, blank_attr} : 32'd0;

  // Hold the blank attribute
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attr <= BLANK_ATTR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      blank_attr <= pwdata[7:0];
    end
  end

  tmtw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .blank_attr (blank_attr),
    .lin        (lin),
    .rdata      (rdata),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .req        (req),
    .top_base   (top_base)
  );

  tmtw_addr_unit u_addr (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .top_base (top_base),
    .cmd      (cmd),
    .lin      (lin)
  );

  tmtw_screen_mem u_mem (
    .clk   (clk),
    .cmd   (cmd),
    .rdata (rdata)
  );

endmodule
